>>> hdl/lphd_pkg.sv
// Shared types, constants and helpers for the linear-probe hash directory.
// No dependencies; used by linear_probe_hash_directory and its testbench.
package lphd_pkg;

    // Table geometry (slot count must stay a power of two: wrap and hash use truncation)
    localparam int TABLE_SLOTS = 1024;
    localparam int KEY_CHARS   = 8;
    localparam int SLOT_W      = $clog2(TABLE_SLOTS);
    localparam int HASH_MULT   = 31;
    localparam int HASH_W      = SLOT_W + 9;

    // Fixed field widths
    localparam int SLOT_INDEX_W = 10;

    localparam logic [3:0] KEY_CHARS_L = 4'(KEY_CHARS);

    // Operation codes
    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_SEARCH = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;

    // Status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_DUP  = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;
    localparam logic [1:0] ST_MISS = 2'd3;

    typedef struct packed {
        logic [1:0]  operation;
        logic [63:0] name_key;
        logic [3:0]  name_length;
        logic [12:0] first_block;
        logic [23:0] byte_count;
    } req_t;

    typedef struct packed {
        logic [1:0]              status;
        logic [SLOT_INDEX_W-1:0] slot_index;
        logic [12:0]             found_block;
        logic [23:0]             found_size;
    } rsp_t;

    // One slot as held in the slot memory
    typedef struct packed {
        logic        valid;
        logic [63:0] key;
        logic [3:0]  key_length;
        logic [12:0] block;
        logic [23:0] size;
    } slot_entry_t;

    localparam int ENTRY_W = $bits(slot_entry_t);

    // Clamp the length to the key capacity
    function automatic logic [3:0] sat_length(input logic [3:0] len);
        return (len > KEY_CHARS_L) ? KEY_CHARS_L : len;
    endfunction

    // Zero the key bytes at and above the length
    function automatic logic [63:0] mask_key(input logic [63:0] key, input logic [3:0] len);
        logic [63:0] res;
        res = '0;
        for (int b = 0; b < 8; b++) begin
            if (len > 4'(b)) begin
                res[8*b +: 8] = key[8*b +: 8];
            end
        end
        return res;
    endfunction

    // Polynomial hash, reduced to the slot count after every byte
    function automatic logic [SLOT_W-1:0] home_slot(input logic [63:0] key,
                                                     input logic [3:0] len);
        logic [SLOT_W-1:0] h;
        logic [HASH_W-1:0] acc;
        h   = '0;
        acc = '0;
        for (int i = 0; i < KEY_CHARS; i++) begin
            if (len > 4'(i)) begin
                acc = HASH_W'(h) * HASH_W'(HASH_MULT) + HASH_W'(key[8*i +: 8]);
                h   = acc[SLOT_W-1:0];
            end
        end
        return h;
    endfunction

endpackage

>>> hdl/lphd_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// No dependencies.
module lphd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port, registered read data
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> hdl/linear_probe_hash_directory.sv
// Top level of the linear-probe hash directory: sequencer, probe logic, output register.
// Depends on lphd_pkg and lphd_ram.
//
// Usage:
//   Request channel (req_valid / req_stall / req) carries one transaction per
//   operation: insert, search or remove of a name key of up to eight bytes.
//   Response channel (rsp_valid / rsp_stall / rsp) returns exactly one
//   transaction per request, in order: status, slot, and the stored block and
//   size on a search hit.
//   All slots live in a single slot memory (1024 entries, one read and one
//   write port, registered read data). One request is worked at a time:
//   the key is hashed, the slots are probed one after another from the home
//   slot, then the response register is loaded; a full wrap costs up to
//   1024 probes. After reset the block sweeps the slot memory clearing every
//   valid mark, one slot per cycle, through all 1024 slots; req_stall stays
//   high meanwhile. A new request may be accepted while the previous
//   response still waits in the output register. When rsp_stall holds the
//   response, the block finishes its current request and then waits before
//   loading the next one.
module linear_probe_hash_directory (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  lphd_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output lphd_pkg::rsp_t rsp
);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_HASH  = 3'd2;
    localparam logic [2:0] S_PROBE = 3'd3;
    localparam logic [2:0] S_EMIT  = 3'd4;

    localparam logic [lphd_pkg::SLOT_W-1:0] LAST_SLOT =
        lphd_pkg::SLOT_W'(lphd_pkg::TABLE_SLOTS - 1);

    logic [2:0] state_reg, state_next;
    logic [lphd_pkg::SLOT_W-1:0] clr_cnt_reg, clr_cnt_next;
    logic [lphd_pkg::SLOT_W-1:0] idx_reg, idx_next;
    logic [lphd_pkg::SLOT_W-1:0] home_reg, home_next;
    lphd_pkg::req_t req_reg, req_next;
    lphd_pkg::rsp_t res_reg, res_next;
    lphd_pkg::rsp_t out_reg, out_next;
    logic out_valid_reg, out_valid_next;

    logic req_fire;
    logic out_load;
    logic [lphd_pkg::SLOT_W-1:0] home_hash;
    logic [lphd_pkg::SLOT_W-1:0] next_idx;
    logic hit;
    logic wrap;

    logic ram_we;
    logic ram_re;
    logic [lphd_pkg::SLOT_W-1:0] ram_waddr;
    logic [lphd_pkg::SLOT_W-1:0] ram_raddr;
    lphd_pkg::slot_entry_t ram_wentry;
    lphd_pkg::slot_entry_t rd_entry;
    logic [lphd_pkg::ENTRY_W-1:0] ram_rdata;

    // Slot memory
    lphd_ram #(
        .WIDTH (lphd_pkg::ENTRY_W),
        .DEPTH (lphd_pkg::TABLE_SLOTS)
    ) u_slots (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wentry),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Handshake
    assign req_stall = (state_reg != S_IDLE);
    assign req_fire  = req_valid && !req_stall;
    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;
    assign out_load  = (state_reg == S_EMIT) && (!out_valid_reg || !rsp_stall);

    // Probe datapath
    assign home_hash = lphd_pkg::home_slot(req_reg.name_key, req_reg.name_length);
    assign rd_entry  = lphd_pkg::slot_entry_t'(ram_rdata);
    assign next_idx  = idx_reg + 1'b1;
    assign wrap      = (next_idx == home_reg);
    assign hit       = rd_entry.valid && (rd_entry.key_length == req_reg.name_length)
                       && (rd_entry.key == req_reg.name_key);

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        idx_next       = idx_reg;
        home_next      = home_reg;
        req_next       = req_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && rsp_stall;
        ram_we         = 1'b0;
        ram_re         = 1'b0;
        ram_waddr      = idx_reg;
        ram_raddr      = idx_reg;
        ram_wentry     = '0;

        unique case (state_reg)
            S_CLEAR:
            begin
                ram_we       = 1'b1;
                ram_waddr    = clr_cnt_reg;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == LAST_SLOT)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_fire)
                begin
                    req_next             = req;
                    req_next.name_length = lphd_pkg::sat_length(req.name_length);
                    req_next.name_key    = lphd_pkg::mask_key(req.name_key,
                                               lphd_pkg::sat_length(req.name_length));
                    state_next           = S_HASH;
                end
            end
            S_HASH:
            begin
                if (req_reg.operation != lphd_pkg::OP_INSERT
                    && req_reg.operation != lphd_pkg::OP_SEARCH
                    && req_reg.operation != lphd_pkg::OP_REMOVE)
                begin
                    res_next        = '0;
                    res_next.status = lphd_pkg::ST_MISS;
                    state_next      = S_EMIT;
                end
                else
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = home_hash;
                    idx_next   = home_hash;
                    home_next  = home_hash;
                    state_next = S_PROBE;
                end
            end
            S_PROBE:
            begin
                res_next        = '0;
                res_next.status = lphd_pkg::ST_MISS;
                if (hit)
                begin
                    state_next = S_EMIT;
                    case (req_reg.operation)
                        lphd_pkg::OP_INSERT:
                        begin
                            res_next.status = lphd_pkg::ST_DUP;
                        end
                        lphd_pkg::OP_SEARCH:
                        begin
                            res_next.status      = lphd_pkg::ST_OK;
                            res_next.slot_index  = lphd_pkg::SLOT_INDEX_W'(idx_reg);
                            res_next.found_block = rd_entry.block;
                            res_next.found_size  = rd_entry.size;
                        end
                        default:
                        begin
                            // remove: clear the valid mark, no tombstone
                            res_next.status    = lphd_pkg::ST_OK;
                            res_next.slot_index = lphd_pkg::SLOT_INDEX_W'(idx_reg);
                            ram_we             = 1'b1;
                            ram_wentry         = rd_entry;
                            ram_wentry.valid   = 1'b0;
                        end
                    endcase
                end
                else if (!rd_entry.valid)
                begin
                    // empty slot ends the chain
                    state_next = S_EMIT;
                    if (req_reg.operation == lphd_pkg::OP_INSERT)
                    begin
                        res_next.status       = lphd_pkg::ST_OK;
                        res_next.slot_index   = lphd_pkg::SLOT_INDEX_W'(idx_reg);
                        ram_we                = 1'b1;
                        ram_wentry.valid      = 1'b1;
                        ram_wentry.key        = req_reg.name_key;
                        ram_wentry.key_length = req_reg.name_length;
                        ram_wentry.block      = req_reg.first_block;
                        ram_wentry.size       = req_reg.byte_count;
                    end
                end
                else if (wrap)
                begin
                    state_next = S_EMIT;
                    if (req_reg.operation == lphd_pkg::OP_INSERT)
                    begin
                        res_next.status = lphd_pkg::ST_FULL;
                    end
                end
                else
                begin
                    ram_re    = 1'b1;
                    ram_raddr = next_idx;
                    idx_next  = next_idx;
                    res_next  = res_reg;
                end
            end
            S_EMIT:
            begin
                if (out_load)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        idx_reg  <= idx_next;
        home_reg <= home_next;
        req_reg  <= req_next;
        res_reg  <= res_next;
        out_reg  <= out_next;
    end

    // Assertions
    a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(ram_we && ram_re))
        else $error("slot memory read and write in the same cycle");

    a_accept_to_hash: assert property (@(posedge clk) disable iff (!rst_n)
        req_fire |=> (state_reg == S_HASH))
        else $error("accepted request did not start hashing");

    a_write_ends_probe: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PROBE && ram_we) |=> (state_reg == S_EMIT))
        else $error("slot write did not end the probe");

    a_emit_loads: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> (rsp_valid && rsp == $past(res_reg)))
        else $error("response register not loaded from result");

    a_full_no_slot: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp.status != lphd_pkg::ST_FULL || rsp.slot_index == '0))
        else $error("table full response carries a slot");

endmodule

>>> sim/tb_linear_probe_hash_directory.sv
`timescale 1ns / 1ps
// Testbench for linear_probe_hash_directory: directed and random directory traffic,
// each response checked against a slot table that the bench keeps for itself.
// Depends on lphd_pkg and the RTL of linear_probe_hash_directory.
module tb_linear_probe_hash_directory;

    // Operation code that the block must treat as a no-op
    localparam logic [1:0] OP_UNDEFINED = 2'd3;

    typedef struct {
        logic [63:0] key;
        logic [3:0]  len;
    } name_t;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    lphd_pkg::req_t req = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    lphd_pkg::rsp_t rsp;

    // Bench copy of the directory
    bit          dir_valid [lphd_pkg::TABLE_SLOTS];
    logic [63:0] dir_key   [lphd_pkg::TABLE_SLOTS];
    logic [3:0]  dir_len   [lphd_pkg::TABLE_SLOTS];
    logic [12:0] dir_block [lphd_pkg::TABLE_SLOTS];
    logic [23:0] dir_bytes [lphd_pkg::TABLE_SLOTS];
    int          dir_used = 0;
    int          dir_peak = 0;

    lphd_pkg::rsp_t pending_replies[$];
    lphd_pkg::rsp_t last_outcome;
    name_t          live_names[$];
    bit             no_idle = 1'b0;

    int error_count     = 0;
    int results_checked = 0;
    int n_insert = 0, n_search = 0, n_remove = 0, n_other = 0;
    int n_full = 0, n_dup = 0, n_miss = 0;

    linear_probe_hash_directory u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Bytes that count for a given length (length saturates at the key capacity)
    function automatic logic [63:0] byte_mask(input logic [3:0] len);
        logic [63:0] m;
        m = '0;
        for (int b = 0; b < lphd_pkg::KEY_CHARS; b++)
        begin
            if (len > b)
            begin
                m[8*b +: 8] = 8'hFF;
            end
        end
        return m;
    endfunction

    // Works out the response of one request and updates the bench table
    function automatic lphd_pkg::rsp_t directory_outcome(input lphd_pkg::req_t r);
        lphd_pkg::rsp_t res;
        int             n, home, idx;
        logic [63:0]    k;
        bit             hit, wrapped;
        res        = '0;
        res.status = lphd_pkg::ST_MISS;
        n          = (r.name_length > lphd_pkg::KEY_CHARS) ? lphd_pkg::KEY_CHARS
                                                            : int'(r.name_length);
        k          = r.name_key & byte_mask(r.name_length);
        if (r.operation != OP_UNDEFINED)
        begin
            home = 0;
            for (int i = 0; i < n; i++)
            begin
                home = (home * lphd_pkg::HASH_MULT + int'(k[8*i +: 8]))
                       % lphd_pkg::TABLE_SLOTS;
            end
            // walk until empty slot, matching key, or back at home
            idx     = home;
            hit     = 1'b0;
            wrapped = 1'b0;
            while (dir_valid[idx] && !hit && !wrapped)
            begin
                if (dir_len[idx] == n && dir_key[idx] == k)
                begin
                    hit = 1'b1;
                end
                else
                begin
                    idx = (idx + 1) % lphd_pkg::TABLE_SLOTS;
                    if (idx == home)
                    begin
                        wrapped = 1'b1;
                    end
                end
            end
            case (r.operation)
                lphd_pkg::OP_INSERT:
                begin
                    if (hit)
                    begin
                        res.status = lphd_pkg::ST_DUP;
                        n_dup++;
                    end
                    else if (wrapped)
                    begin
                        res.status = lphd_pkg::ST_FULL;
                        n_full++;
                    end
                    else
                    begin
                        dir_valid[idx] = 1'b1;
                        dir_key[idx]   = k;
                        dir_len[idx]   = 4'(n);
                        dir_block[idx] = r.first_block;
                        dir_bytes[idx] = r.byte_count;
                        dir_used++;
                        if (dir_used > dir_peak)
                        begin
                            dir_peak = dir_used;
                        end
                        res.status     = lphd_pkg::ST_OK;
                        res.slot_index = lphd_pkg::SLOT_INDEX_W'(idx);
                    end
                end
                lphd_pkg::OP_SEARCH:
                begin
                    if (hit)
                    begin
                        res.status      = lphd_pkg::ST_OK;
                        res.slot_index  = lphd_pkg::SLOT_INDEX_W'(idx);
                        res.found_block = dir_block[idx];
                        res.found_size  = dir_bytes[idx];
                    end
                end
                default:
                begin
                    if (hit)
                    begin
                        res.status     = lphd_pkg::ST_OK;
                        res.slot_index = lphd_pkg::SLOT_INDEX_W'(idx);
                        dir_valid[idx] = 1'b0;
                        dir_used--;
                    end
                end
            endcase
        end
        if (res.status == lphd_pkg::ST_MISS)
        begin
            n_miss++;
        end
        return res;
    endfunction

    function automatic lphd_pkg::req_t make_req(input logic [1:0] op,
                                                input logic [63:0] key,
                                                input logic [3:0] len,
                                                input logic [12:0] blk,
                                                input logic [23:0] size);
        lphd_pkg::req_t r;
        r.operation   = op;
        r.name_key    = key;
        r.name_length = len;
        r.first_block = blk;
        r.byte_count  = size;
        return r;
    endfunction

    // Same name, different junk above the length; full-length names get lengths 8..15
    function automatic name_t respell(input name_t nm);
        name_t       out;
        logic [63:0] m;
        m       = byte_mask(nm.len);
        out.key = (nm.key & m) | ({$urandom, $urandom} & ~m);
        out.len = (nm.len >= lphd_pkg::KEY_CHARS)
                  ? 4'($urandom_range(lphd_pkg::KEY_CHARS, 15)) : nm.len;
        return out;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        error_count++;
        if (error_count <= 100)
        begin
            $display("[%0t] mismatch on %s: got %0h, expected %0h", $time, what, got, want);
        end
    endtask

    // Drive one transaction, hold it until accepted, then log its expected response
    task automatic send_request(input lphd_pkg::req_t item);
        @(negedge clk);
        while (!no_idle && $urandom_range(99) < 20)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req       <= item;
        req_valid <= 1'b1;
        @(posedge clk);
        while (req_stall !== 1'b0)
        begin
            @(posedge clk);
        end
        last_outcome = directory_outcome(item);
        pending_replies.insert(pending_replies.size(), last_outcome);
        case (item.operation)
            lphd_pkg::OP_INSERT: n_insert++;
            lphd_pkg::OP_SEARCH: n_search++;
            lphd_pkg::OP_REMOVE: n_remove++;
            default:             n_other++;
        endcase
    endtask

    // Response side stalls at random
    always @(negedge clk)
    begin
        rsp_stall <= rst_n && !no_idle && ($urandom_range(99) < 20);
    end

    // Compare every accepted response with the oldest expectation
    always @(posedge clk)
    begin : check_replies
        lphd_pkg::rsp_t want;
        if (rst_n && rsp_valid === 1'b1 && rsp_stall === 1'b0)
        begin
            if (pending_replies.size() == 0)
            begin
                report_mismatch("response with nothing pending", 64'(rsp), 64'd0);
            end
            else
            begin
                want = pending_replies.pop_front();
                results_checked++;
                if (rsp.status !== want.status)
                begin
                    report_mismatch("status", 64'(rsp.status), 64'(want.status));
                end
                if (rsp.slot_index !== want.slot_index)
                begin
                    report_mismatch("slot_index", 64'(rsp.slot_index),
                                    64'(want.slot_index));
                end
                if (rsp.found_block !== want.found_block)
                begin
                    report_mismatch("found_block", 64'(rsp.found_block),
                                    64'(want.found_block));
                end
                if (rsp.found_size !== want.found_size)
                begin
                    report_mismatch("found_size", 64'(rsp.found_size),
                                    64'(want.found_size));
                end
            end
        end
    end

    // Empty key, all-ones key, length saturation, bytes above the length
    task automatic test_key_edges();
        send_request(make_req(lphd_pkg::OP_INSERT, 64'h0, 4'd0, 13'd0, 24'd0));
        send_request(make_req(lphd_pkg::OP_INSERT, {$urandom, $urandom}, 4'd0, 13'h1FFF,
                              24'hFFFFFF));
        send_request(make_req(lphd_pkg::OP_SEARCH, '1, 4'd0, 13'($urandom),
                              24'($urandom)));
        send_request(make_req(lphd_pkg::OP_INSERT, '1, 4'd8, 13'h1FFF, 24'hFFFFFF));
        send_request(make_req(lphd_pkg::OP_SEARCH, '1, 4'd15, 13'($urandom),
                              24'($urandom)));
        // "abc" with junk in the upper bytes
        send_request(make_req(lphd_pkg::OP_INSERT, 64'hDEAD_BEEF_A563_6261, 4'd3, 13'd1,
                              24'd1));
        send_request(make_req(lphd_pkg::OP_SEARCH, 64'h0123_4567_8963_6261, 4'd3, 13'd0,
                              24'd0));
        send_request(make_req(lphd_pkg::OP_SEARCH, 64'h0000_0000_0063_6261, 4'd2, 13'd0,
                              24'd0));
        send_request(make_req(lphd_pkg::OP_INSERT, 64'h1234_5678_9ABC_DEF0, 4'd9, 13'h0AAA,
                              24'h555555));
        send_request(make_req(lphd_pkg::OP_SEARCH, 64'h1234_5678_9ABC_DEF0, 4'd8, 13'd0,
                              24'd0));
    endtask

    // Probe chains: wrap past the last slot, and removal without a tombstone
    task automatic test_collisions();
        // 0x0021 and 0x1F20 both hash to the last slot
        send_request(make_req(lphd_pkg::OP_INSERT, 64'h0021, 4'd2, 13'd21, 24'd2100));
        send_request(make_req(lphd_pkg::OP_INSERT, 64'h1F20, 4'd2, 13'd20, 24'd2000));
        send_request(make_req(lphd_pkg::OP_SEARCH, 64'h1F20, 4'd2, 13'd0, 24'd0));
        send_request(make_req(lphd_pkg::OP_REMOVE, 64'h0021, 4'd2, 13'd0, 24'd0));
        send_request(make_req(lphd_pkg::OP_SEARCH, 64'h1F20, 4'd2, 13'd0, 24'd0));
        // "A" and 0x0302 share a home slot
        send_request(make_req(lphd_pkg::OP_INSERT, 64'h41, 4'd1, 13'd65, 24'd65));
        send_request(make_req(lphd_pkg::OP_INSERT, 64'h0302, 4'd2, 13'd66, 24'd66));
        send_request(make_req(lphd_pkg::OP_REMOVE, 64'h41, 4'd1, 13'd0, 24'd0));
        send_request(make_req(lphd_pkg::OP_SEARCH, 64'h0302, 4'd2, 13'd0, 24'd0));
        send_request(make_req(lphd_pkg::OP_INSERT, 64'h0302, 4'd2, 13'd7, 24'd7));
    endtask

    // Undefined operation has no effect and answers miss; then a search and a remove follow
    task automatic test_odd_operation();
        send_request(make_req(OP_UNDEFINED, '1, 4'd8, 13'h1FFF, 24'hFFFFFF));
        send_request(make_req(OP_UNDEFINED, {$urandom, $urandom}, 4'($urandom),
                              13'($urandom), 24'($urandom)));
        send_request(make_req(lphd_pkg::OP_SEARCH, '1, 4'd8, 13'd0, 24'd0));
        send_request(make_req(lphd_pkg::OP_REMOVE, {$urandom, $urandom}, 4'd8, 13'd0,
                              24'd0));
    endtask

    // Random insert/search/remove, searches and removes mostly of live names, with noise mixed in
    task automatic test_random_traffic(input int count);
        int    r, pos;
        bit    reuse;
        name_t nm;
        for (int i = 0; i < count; i++)
        begin
            no_idle = (i >= 300 && i < 500);
            r       = $urandom_range(99);
            if (live_names.size() > 250 && r >= 4 && r < 44 && $urandom_range(1) == 1)
            begin
                r = 90;
            end
            nm.key = {$urandom, $urandom};
            nm.len = ($urandom_range(9) == 0) ? 4'($urandom_range(9, 15))
                                              : 4'($urandom_range(0, 8));
            pos    = (live_names.size() > 0) ? $urandom_range(live_names.size() - 1) : 0;
            reuse  = (live_names.size() > 0) && ($urandom_range(3) != 0);
            if (r < 4)
            begin
                send_request(make_req(OP_UNDEFINED, nm.key, 4'($urandom), 13'($urandom),
                                      24'($urandom)));
            end
            else if (r < 44)
            begin
                // occasional duplicate insert of a live name
                if (live_names.size() > 0 && $urandom_range(9) == 0)
                begin
                    nm = respell(live_names[pos]);
                end
                send_request(make_req(lphd_pkg::OP_INSERT, nm.key, nm.len, 13'($urandom),
                                      24'($urandom)));
                if (last_outcome.status == lphd_pkg::ST_OK)
                begin
                    live_names.insert(live_names.size(), nm);
                end
            end
            else if (r < 72)
            begin
                if (reuse)
                begin
                    nm = respell(live_names[pos]);
                end
                send_request(make_req(lphd_pkg::OP_SEARCH, nm.key, nm.len, 13'($urandom),
                                      24'($urandom)));
            end
            else
            begin
                if (reuse)
                begin
                    nm = respell(live_names[pos]);
                end
                send_request(make_req(lphd_pkg::OP_REMOVE, nm.key, nm.len, 13'($urandom),
                                      24'($urandom)));
                if (reuse && last_outcome.status == lphd_pkg::ST_OK)
                begin
                    live_names.delete(pos);
                end
            end
        end
        no_idle = 1'b0;
    endtask

    // Fill every slot, then exercise full-table insert and full-wrap misses
    task automatic test_full_table();
        int          guard;
        logic [63:0] key;
        name_t       last_in;
        guard   = 0;
        last_in = '{64'h0, 4'd0};
        while (dir_used < lphd_pkg::TABLE_SLOTS && guard < 2 * lphd_pkg::TABLE_SLOTS)
        begin
            key = {$urandom, $urandom};
            send_request(make_req(lphd_pkg::OP_INSERT, key, 4'd8, 13'($urandom),
                                  24'($urandom)));
            if (last_outcome.status == lphd_pkg::ST_OK)
            begin
                last_in = '{key, 4'd8};
            end
            guard++;
        end
        key = {$urandom, $urandom};
        send_request(make_req(lphd_pkg::OP_INSERT, key, 4'd8, 13'($urandom), 24'($urandom)));
        send_request(make_req(lphd_pkg::OP_INSERT, last_in.key, last_in.len, 13'd0, 24'd0));
        send_request(make_req(lphd_pkg::OP_SEARCH, key, 4'd8, 13'd0, 24'd0));
        send_request(make_req(lphd_pkg::OP_REMOVE, key, 4'd8, 13'd0, 24'd0));
        send_request(make_req(lphd_pkg::OP_SEARCH, last_in.key, last_in.len, 13'd0, 24'd0));
        send_request(make_req(lphd_pkg::OP_REMOVE, last_in.key, last_in.len, 13'd0, 24'd0));
        send_request(make_req(lphd_pkg::OP_INSERT, key, 4'd8, 13'h1FFF, 24'hFFFFFF));
        send_request(make_req(lphd_pkg::OP_INSERT, {$urandom, $urandom}, 4'd8, 13'd3,
                              24'd3));
        send_request(make_req(lphd_pkg::OP_SEARCH, key, 4'd8, 13'd0, 24'd0));
    endtask

    initial
    begin : run_tests
        int wait_cycles;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_key_edges();
        test_collisions();
        test_odd_operation();
        test_random_traffic(1000);
        test_full_table();

        @(negedge clk);
        req_valid <= 1'b0;

        // drain, then give the block time to show any stray response
        wait_cycles = 0;
        while (pending_replies.size() != 0 && wait_cycles < 20000)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (40) @(posedge clk);
        if (pending_replies.size() != 0)
        begin
            report_mismatch("responses never delivered", 64'(pending_replies.size()),
                            64'd0);
        end

        $display("covered %0d requests: %0d insert, %0d search, %0d remove, %0d undefined op",
                 n_insert + n_search + n_remove + n_other, n_insert, n_search, n_remove,
                 n_other);
        $display("%0d responses checked; peak occupancy %0d/%0d; %0d full, %0d dup, %0d miss",
                 results_checked, dir_peak, lphd_pkg::TABLE_SLOTS, n_full, n_dup, n_miss);
        if (error_count == 0)
        begin
            $display("tb_linear_probe_hash_directory: done, clean");
        end
        else
        begin
            $display("tb_linear_probe_hash_directory: done, errors");
        end
        $finish;
    end

    // Hang guard: far beyond the slowest legal run
    initial
    begin
        #100_000_000;
        $display("tb_linear_probe_hash_directory: done, errors");
        $finish;
    end

endmodule

>>> filelist.f
hdl/lphd_pkg.sv
hdl/lphd_ram.sv
hdl/linear_probe_hash_directory.sv
sim/tb_linear_probe_hash_directory.sv
